// ===== hdl/sorted_matrix_staircase_search_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted matrix staircase search
// Checks are compiled in simulation and drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_DEFINES_SVH
`ifndef SYNTH
`define SMSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("staircase search check failed");
`define SMSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("staircase search check failed");
`else
`define SMSS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SMSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/smss_pkg.sv =====
// ----------------------------------------------------------------------------
// Staircase search package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smss_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int IDX_W   = 11;
    localparam int SIZE_W  = 7;
    localparam int POS_W   = 6;
    localparam int VALUE_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic walk_end;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/smss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/smss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Staircase search controller
// Sequences item acceptance, the walk through the matrix and result hand-off.
// ----------------------------------------------------------------------------
`include "sorted_matrix_staircase_search_defines.svh"

module smss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    output logic              o_in_stall,
    input  smss_pkg::t_status i_status,
    output smss_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    smss_pkg::t_cmd cmd;
    logic           idle_cmd_ok;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == smss_pkg::MODE_QUERY) begin
                        cmd.start = 1'b1;
                        n_state   = S_WALK;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (i_status.walk_end) begin
                    cmd.finish = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cmd       = cmd;
    assign idle_cmd_ok = $onehot0({cmd.load, cmd.start, cmd.step, cmd.finish, cmd.load_out});

    `SMSS_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n, 1'b1, idle_cmd_ok)
    `SMSS_ASSERT_NEXT(a_start_walks, i_clk, i_rst_n, cmd.start, r_state == S_WALK)
    `SMSS_ASSERT_NEXT(a_out_to_idle, i_clk, i_rst_n, cmd.load_out, r_state == S_IDLE)

endmodule

// ===== hdl/smss_dpath.sv =====
// ----------------------------------------------------------------------------
// Staircase search datapath
// Holds the size registers, the cell memory, the walk position and the result.
// ----------------------------------------------------------------------------
`include "sorted_matrix_staircase_search_defines.svh"

module smss_dpath #(
    parameter int MAX_ROWS = smss_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = smss_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smss_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic [smss_pkg::POS_W-1:0]          i_row_index,
    input  logic [smss_pkg::POS_W-1:0]          i_col_index,
    input  logic signed [smss_pkg::VALUE_W-1:0] i_value,
    input  smss_pkg::t_cmd                      i_cmd,
    output smss_pkg::t_status                   o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_found,
    output logic [smss_pkg::POS_W-1:0]          o_found_row,
    output logic [smss_pkg::POS_W-1:0]          o_found_col
);

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_CNT_W = ROW_W + 1;
    localparam int COL_CNT_W = COL_W + 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = 1 << ADDR_W;

    localparam logic [smss_pkg::IDX_W-1:0] ROW_LIM = smss_pkg::IDX_W'(MAX_ROWS);
    localparam logic [smss_pkg::IDX_W-1:0] COL_LIM = smss_pkg::IDX_W'(MAX_COLS);

    logic [smss_pkg::SIZE_W-1:0]         r_rows_in_use;
    logic [smss_pkg::SIZE_W-1:0]         r_cols_in_use;
    logic [ROW_CNT_W-1:0]                r_i;
    logic [COL_CNT_W-1:0]                r_j;
    logic [ROW_CNT_W-1:0]                n_i;
    logic [COL_CNT_W-1:0]                n_j;
    logic signed [smss_pkg::VALUE_W-1:0] r_key;
    logic                                r_hit;
    logic                                r_out_valid;
    logic                                r_found;
    logic [smss_pkg::POS_W-1:0]          r_found_row;
    logic [smss_pkg::POS_W-1:0]          r_found_col;

    logic [smss_pkg::IDX_W-1:0]          rows_ext;
    logic [smss_pkg::IDX_W-1:0]          cols_ext;
    logic [smss_pkg::IDX_W-1:0]          nrows_w;
    logic [smss_pkg::IDX_W-1:0]          ncols_w;
    logic [ROW_CNT_W-1:0]                nrows;
    logic [COL_CNT_W-1:0]                ncols;
    logic [smss_pkg::IDX_W-1:0]          ld_row_ext;
    logic [smss_pkg::IDX_W-1:0]          ld_col_ext;
    logic                                ld_ok;
    logic [ADDR_W-1:0]                   waddr;
    logic [ADDR_W-1:0]                   raddr;
    logic [COL_CNT_W-1:0]                start_col;
    logic [COL_CNT_W-1:0]                step_col;
    logic [COL_CNT_W-1:0]                cur_col;
    logic signed [smss_pkg::VALUE_W-1:0] cur_cell;
    logic [smss_pkg::VALUE_W-1:0]        rdata;
    logic                                in_range;
    logic                                eq;
    logic                                lt;
    logic                                out_free;
    logic [smss_pkg::IDX_W-1:0]          hit_row_ext;
    logic [smss_pkg::IDX_W-1:0]          hit_col_ext;
    logic                                miss_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= smss_pkg::SIZE_RESET;
            r_cols_in_use <= smss_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smss_pkg::CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                smss_pkg::CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows_ext = smss_pkg::IDX_W'(r_rows_in_use);
    assign cols_ext = smss_pkg::IDX_W'(r_cols_in_use);
    assign nrows_w  = (rows_ext > ROW_LIM) ? ROW_LIM : rows_ext;
    assign ncols_w  = (cols_ext > COL_LIM) ? COL_LIM : cols_ext;
    assign nrows    = nrows_w[ROW_CNT_W-1:0];
    assign ncols    = ncols_w[COL_CNT_W-1:0];

    assign ld_row_ext = smss_pkg::IDX_W'(i_row_index);
    assign ld_col_ext = smss_pkg::IDX_W'(i_col_index);
    assign ld_ok      = (ld_row_ext < ROW_LIM) && (ld_col_ext < COL_LIM);
    assign waddr      = {ld_row_ext[ROW_W-1:0], ld_col_ext[COL_W-1:0]};

    assign cur_cell = $signed(rdata);
    assign in_range = (r_i < nrows) && (r_j != '0);
    assign eq       = (cur_cell == r_key);
    assign lt       = (cur_cell < r_key);
    assign cur_col  = r_j - COL_CNT_W'(1);

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (lt) begin
            n_i = r_i + ROW_CNT_W'(1);
        end else begin
            n_j = r_j - COL_CNT_W'(1);
        end
    end

    // The read address follows the next position so the cell arrives with it.
    assign start_col = ncols - COL_CNT_W'(1);
    assign step_col  = n_j - COL_CNT_W'(1);
    assign raddr     = i_cmd.start ? {ROW_W'(0), start_col[COL_W-1:0]}
                                   : {n_i[ROW_W-1:0], step_col[COL_W-1:0]};

    smss_ram #(
        .WIDTH (smss_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && ld_ok),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_i   <= '0;
            r_j   <= ncols;
            r_key <= i_value;
        end else if (i_cmd.step) begin
            r_i <= n_i;
            r_j <= n_j;
        end
        if (i_cmd.finish) begin
            r_hit <= in_range && eq;
        end
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign hit_row_ext = smss_pkg::IDX_W'(r_i);
    assign hit_col_ext = smss_pkg::IDX_W'(cur_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_found     <= r_hit;
            r_found_row <= r_hit ? hit_row_ext[smss_pkg::POS_W-1:0] : '0;
            r_found_col <= r_hit ? hit_col_ext[smss_pkg::POS_W-1:0] : '0;
        end
    end

    assign o_status.walk_end = !in_range || eq;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_found_row       = r_found_row;
    assign o_found_col       = r_found_col;
    assign miss_zero         = (r_found_row == '0) && (r_found_col == '0);

    `SMSS_ASSERT_NOW(a_step_in_range, i_clk, i_rst_n, i_cmd.step, (r_j != '0) && (r_i < nrows))
    `SMSS_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, i_cmd.load_out, r_out_valid)
    `SMSS_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_found, miss_zero)

endmodule

// ===== hdl/sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// Sorted matrix staircase search
// Loads cells into a row and column sorted matrix and searches it for a key.
// ----------------------------------------------------------------------------
// A load item is taken without leaving the idle state and gives no result.
// A query walks one cell per cycle from the top-right corner, reading each
// cell through the single read port of the cell memory.
// When the walk ends the hit is registered, and the result register is loaded once it is free; one item is in work.
// Reset sets both size registers to 64 and empties the result register.
// Cell memory contents are not cleared by reset.
module sorted_matrix_staircase_search #(
    parameter int MAX_ROWS = smss_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = smss_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smss_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [smss_pkg::POS_W-1:0]          i_row_index,
    input  logic [smss_pkg::POS_W-1:0]          i_col_index,
    input  logic signed [smss_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [smss_pkg::POS_W-1:0]          o_found_row,
    output logic [smss_pkg::POS_W-1:0]          o_found_col
);

    smss_pkg::t_cmd    cmd;
    smss_pkg::t_status status;

    smss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    smss_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_found_row (o_found_row),
        .o_found_col (o_found_col)
    );

endmodule

// ===== tb/tb_sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sorted matrix staircase search
// Fills the cell memory with row and column sorted matrices, sends query items
// and checks every search result against a cycle-free software walk of its
// own copy of the matrix. Covers empty, clamped and full-size search areas,
// with random sender gaps and random receiver stalls.
// ----------------------------------------------------------------------------
module tb_sorted_matrix_staircase_search;
    import smss_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int FINAL_CYCLES   = 200;
    localparam int RANDOM_QUERIES = 450;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_search_result;

    class t_staircase_tracker;
        logic signed [VALUE_W-1:0] cell_copy [DEF_MAX_ROWS][DEF_MAX_COLS];
        logic [SIZE_W-1:0] rows_used = SIZE_RESET;
        logic [SIZE_W-1:0] cols_used = SIZE_RESET;
        t_search_result expected_searches [$];
        int errors = 0;

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        function void set_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
            if (index == CFG_ROWS_IN_USE) begin
                rows_used = data;
            end else begin
                cols_used = data;
            end
        endfunction

        function int area_rows();
            return (int'(rows_used) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_used);
        endfunction

        function int area_cols();
            return (int'(cols_used) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_used);
        endfunction

        function int pending();
            return expected_searches.size();
        endfunction

        // Start at the top-right cell; move down on a smaller cell, left on a larger one.
        function t_search_result walk_staircase(logic signed [VALUE_W-1:0] key);
            t_search_result res;
            int i;
            int j;
            int nr;
            res = '0;
            nr = area_rows();
            i = 0;
            j = area_cols();
            while (i < nr && j > 0) begin
                if (cell_copy[i][j-1] == key) begin
                    res.found = 1'b1;
                    res.row = POS_W'(i);
                    res.col = POS_W'(j - 1);
                    return res;
                end
                if (cell_copy[i][j-1] < key) begin
                    i++;
                end else begin
                    j--;
                end
            end
            return res;
        endfunction

        function void note_item(logic mode, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                logic signed [VALUE_W-1:0] value);
            if (mode == MODE_LOAD) begin
                cell_copy[row][col] = value;
            end else begin
                expected_searches.insert(expected_searches.size(), walk_staircase(value));
            end
        endfunction

        task check_result(logic found, logic [POS_W-1:0] row, logic [POS_W-1:0] col);
            t_search_result want;
            if (expected_searches.size() == 0) begin
                report($sformatf("result with no query waiting: found=%0b row=%0d col=%0d",
                                 found, row, col));
                return;
            end
            want = expected_searches.pop_front();
            if (found !== want.found) begin
                report($sformatf("found=%0b, expected %0b", found, want.found));
            end
            if (row !== want.row) begin
                report($sformatf("found_row=%0d, expected %0d", row, want.row));
            end
            if (col !== want.col) begin
                report($sformatf("found_col=%0d, expected %0d", col, want.col));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS_IN_USE;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_mode = MODE_LOAD;
    logic [POS_W-1:0] in_row = '0;
    logic [POS_W-1:0] in_col = '0;
    logic signed [VALUE_W-1:0] in_value = '0;
    logic out_stall = 1'b0;
    logic [10:0] stall_phase = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic o_found;
    logic [POS_W-1:0] o_found_row;
    logic [POS_W-1:0] o_found_col;

    t_staircase_tracker sb;
    int burst_left = 0;
    int random_queries = 0;

    sorted_matrix_staircase_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (in_mode),
        .i_row_index (in_row),
        .i_col_index (in_col),
        .i_value     (in_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_found     (o_found),
        .o_found_row (o_found_row),
        .o_found_col (o_found_col)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            sb.check_result(o_found, o_found_row, o_found_col);
        end
        stall_phase <= stall_phase + 1'b1;
        unique case (stall_phase[10:9])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 1) == 1);
            2'd2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= stall_phase[4];
        endcase
    end

    task automatic send_item(input logic mode, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col,
                             input logic signed [VALUE_W-1:0] value);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_row   <= row;
        in_col   <= col;
        in_value <= value;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        sb.note_item(mode, row, col, value);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_data  <= rows;
        @(posedge clk);
        sb.set_size(CFG_ROWS_IN_USE, rows);
        cfg_index <= CFG_COLS_IN_USE;
        cfg_data  <= cols;
        @(posedge clk);
        sb.set_size(CFG_COLS_IN_USE, cols);
        cfg_we <= 1'b0;
    endtask

    // Each cell is at least its upper and left neighbors, saturating at the top.
    task automatic fill_area(input int nr, input int nc, input int inc_max,
                             input logic signed [VALUE_W-1:0] base);
        longint v;
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                if (i == 0 && j == 0) begin
                    v = base;
                end else begin
                    v = (i > 0) ? longint'(sb.cell_copy[i-1][j]) : longint'(VAL_MIN);
                    if (j > 0 && longint'(sb.cell_copy[i][j-1]) > v) begin
                        v = sb.cell_copy[i][j-1];
                    end
                    v = v + longint'($urandom_range(0, inc_max));
                end
                if (v > longint'(VAL_MAX)) begin
                    v = VAL_MAX;
                end
                send_item(MODE_LOAD, POS_W'(i), POS_W'(j), VALUE_W'(v));
            end
        end
    endtask

    // The last column continues down from the top-right cell with values that never decrease.
    task automatic fill_last_col(input int inc_max);
        longint v;
        for (int i = 1; i < DEF_MAX_ROWS; i++) begin
            v = longint'(sb.cell_copy[i-1][DEF_MAX_COLS-1])
                + longint'($urandom_range(0, inc_max));
            if (v > longint'(VAL_MAX)) begin
                v = VAL_MAX;
            end
            send_item(MODE_LOAD, POS_W'(i), POS_W'(DEF_MAX_COLS - 1), VALUE_W'(v));
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_key();
        int sel;
        int nr;
        int nc;
        logic signed [VALUE_W-1:0] k;
        sel = $urandom_range(0, 9);
        nr = sb.area_rows();
        nc = sb.area_cols();
        if (nr == 0 || nc == 0 || sel == 8) begin
            return $urandom;
        end
        if (sel == 9) begin
            return ($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN;
        end
        k = sb.cell_copy[$urandom_range(0, nr - 1)][$urandom_range(0, nc - 1)];
        if (sel == 6) begin
            k = k + 1;
        end else if (sel == 7) begin
            k = k - 1;
        end
        return k;
    endfunction

    // These keys keep a full-size walk on the first row or the last column.
    function automatic logic signed [VALUE_W-1:0] pick_edge_key();
        int r;
        int c;
        r = $urandom_range(0, DEF_MAX_ROWS - 1);
        c = $urandom_range(0, DEF_MAX_COLS - 1);
        unique case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return sb.cell_copy[0][c];
            default: return sb.cell_copy[r][DEF_MAX_COLS-1];
        endcase
    endfunction

    task automatic run_edge_queries(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(MODE_QUERY, POS_W'($urandom), POS_W'($urandom), pick_edge_key());
        end
    endtask

    task automatic run_queries(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(MODE_LOAD, POS_W'($urandom), POS_W'($urandom), $urandom);
            end
            if ($urandom_range(0, 24) == 0) begin
                wait_results();
            end
            send_item(MODE_QUERY, POS_W'($urandom), POS_W'($urandom), pick_key());
        end
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return SIZE_W'($urandom_range(9, 12));
            default: return SIZE_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic random_phase();
        int count;
        write_sizes(random_size(), random_size());
        if (sb.area_rows() * sb.area_cols() != 0) begin
            fill_area(sb.area_rows(), sb.area_cols(),
                      ($urandom_range(0, 1) == 1) ? 2 : 50000,
                      ($urandom_range(0, 4) == 0) ? VAL_MIN : VALUE_W'($urandom));
        end
        count = $urandom_range(5, 40);
        run_queries(count);
        random_queries += count;
    endtask

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("sorted_matrix_staircase_search test failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Only the first row and the last column are written for the full-size area.
        fill_area(1, DEF_MAX_COLS, 200000, VALUE_W'($urandom));
        fill_last_col(200000);
        write_sizes(7'd127, 7'd65);
        run_edge_queries(24);
        write_sizes(7'd1, 7'd127);
        run_queries(20);

        write_sizes(7'd2, 7'd3);
        send_item(MODE_LOAD, 6'd0, 6'd0, VAL_MIN);
        send_item(MODE_LOAD, 6'd0, 6'd1, -32'sd5);
        send_item(MODE_LOAD, 6'd0, 6'd2, 32'sd7);
        send_item(MODE_LOAD, 6'd1, 6'd0, -32'sd3);
        send_item(MODE_LOAD, 6'd1, 6'd1, 32'sd7);
        send_item(MODE_LOAD, 6'd1, 6'd2, VAL_MAX);
        send_item(MODE_LOAD, 6'd63, 6'd63, 32'sh5a5a_a5a5);
        send_item(MODE_QUERY, 6'd63, 6'd63, VAL_MIN);
        send_item(MODE_QUERY, 6'd0, 6'd0, VAL_MAX);
        send_item(MODE_QUERY, 6'd63, 6'd0, 32'sd7);
        send_item(MODE_QUERY, 6'd0, 6'd63, -32'sd5);
        send_item(MODE_QUERY, 6'd21, 6'd42, -32'sd3);
        send_item(MODE_QUERY, 6'd42, 6'd21, 32'sd0);
        send_item(MODE_QUERY, 6'd1, 6'd1, VAL_MIN + 1);
        send_item(MODE_QUERY, 6'd2, 6'd2, VAL_MAX - 1);

        write_sizes(7'd0, 7'd3);
        send_item(MODE_QUERY, 6'd0, 6'd0, 32'sd7);
        send_item(MODE_QUERY, 6'd0, 6'd0, VAL_MIN);
        write_sizes(7'd2, 7'd0);
        send_item(MODE_QUERY, 6'd0, 6'd0, 32'sd7);

        while (random_queries < RANDOM_QUERIES) begin
            random_phase();
        end

        wait_results();
        repeat (FINAL_CYCLES) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d search results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("sorted_matrix_staircase_search test passed");
        end else begin
            $display("sorted_matrix_staircase_search test failed");
        end
        $finish;
    end
endmodule
